// ----- rtl/ssc_pkg.sv -----
package ssc_pkg;

  localparam int MAX_ORDER   = 4;
  localparam int STORE_DEPTH = MAX_ORDER * MAX_ORDER + 5 * MAX_ORDER;
  localparam int BASE_BM     = MAX_ORDER * MAX_ORDER;
  localparam int BASE_B      = BASE_BM + MAX_ORDER;
  localparam int BASE_L      = BASE_B + MAX_ORDER;
  localparam int BASE_KFB    = BASE_L + MAX_ORDER;
  localparam int BASE_KFF    = BASE_KFB + MAX_ORDER;

  // State memory: estimated state, model state, then a scratch row buffer.
  localparam int STATE_DEPTH = 3 * MAX_ORDER;
  localparam int BASE_X      = 0;
  localparam int BASE_XM     = MAX_ORDER;
  localparam int BASE_SCR    = 2 * MAX_ORDER;

  localparam int CAW   = $clog2(STORE_DEPTH);
  localparam int SAW   = $clog2(STATE_DEPTH);
  localparam int NW    = $clog2(MAX_ORDER + 1);
  localparam int TW    = $clog2(MAX_ORDER + 2);
  localparam int ACC_W = 52;

  typedef logic signed [31:0]      q_t;
  typedef logic signed [ACC_W-1:0] acc_t;

  typedef enum logic [1:0] {
    CLAMP_NONE = 2'd0,
    CLAMP_HIGH = 2'd1,
    CLAMP_LOW  = 2'd2
  } clamp_t;

  localparam logic       CMD_WRITE  = 1'b0;
  localparam logic       CMD_SAMPLE = 1'b1;

  localparam logic [1:0] REG_ORDER = 2'd0;
  localparam logic [1:0] REG_KI    = 2'd1;
  localparam logic [1:0] REG_UMAX  = 2'd2;
  localparam logic [1:0] REG_UMIN  = 2'd3;

  function automatic q_t sat32(input acc_t v);
    acc_t hi;
    acc_t lo;
    hi = acc_t'(q_t'(32'sh7fffffff));
    lo = acc_t'(q_t'(32'sh80000000));
    if (v > hi) begin
      sat32 = 32'sh7fffffff;
    end else if (v < lo) begin
      sat32 = 32'sh80000000;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

// ----- rtl/ssc_ram.sv -----
module ssc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/state_space_servo_controller_core.sv -----
// State-space servo controller core.
// Input channel (in_valid/in_ready): each beat is either a coefficient write
// (in_cmd = 0, in_coef_index, in_coef_value) or a control sample (in_cmd = 1,
// in_reference, in_measurement). A write beat is taken only when the core is
// idle and lands in the coefficient memory at once; it gives no result.
// A sample beat gives one result beat on the output channel (out_valid/
// out_ready) with the clamped control value, the feedback and feedforward
// terms and the clamp status.
// One multiply-accumulate unit does all the multiplying, fed from the
// coefficient memory and the state memory, one term per cycle with a
// three-stage pipe. Each dot product issues its terms, drains the pipe and
// then stores its sum, and each state vector update ends with a copy out of
// the scratch rows. Once the result of a sample appears, the core can take
// the next beat in the following cycle.
// A finished result sits in the output register while the core goes back to
// take the next beat; if the receiver stalls, the next sample waits at its
// end until the output register is free.
// Reset (synchronous, active low) restores the configuration defaults and
// marks every memory entry as unwritten, so it reads as zero; no clearing
// pass is needed.
module state_space_servo_controller_core
  import ssc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_cmd,
  input  logic [5:0]  in_coef_index,
  input  q_t          in_coef_value,
  input  q_t          in_reference,
  input  q_t          in_measurement,
  output logic        out_valid,
  input  logic        out_ready,
  output q_t          out_control,
  output q_t          out_feedback_term,
  output q_t          out_feedforward_term,
  output logic [1:0]  out_clamp_status
);

  typedef enum logic [3:0] {
    S_IDLE, S_ISSUE, S_WAIT, S_DONE, S_COPY, S_COPY_W, S_BASE, S_CLAMP, S_FINISH
  } state_t;

  // Which dot product the shared MAC is working on.
  typedef enum logic [2:0] {
    PH_FB, PH_MODEL, PH_FF, PH_INT, PH_OBS
  } phase_t;

  state_t       state_r;
  phase_t       phase_r;
  logic [NW-1:0] row_r;
  logic [TW-1:0] term_r;
  logic          wait_r;

  // Configuration registers.
  logic [2:0] order_r;
  q_t         ki_r, umax_r, umin_r;

  // Per-sample working registers.
  q_t     r_r, y_r, diff_ry_r, diff_yx_r, x0_r, u_r;
  q_t     fb_r, ff_r, base_r, integ_r;
  clamp_t status_r;

  // Output register.
  logic   out_valid_r;
  q_t     out_u_r, out_fb_r, out_ff_r;
  clamp_t out_st_r;

  // Written marks; an unwritten entry reads as zero.
  logic [STORE_DEPTH-1:0] cvalid_r;
  logic [STATE_DEPTH-1:0] svalid_r;

  // MAC pipeline.
  logic   s1_valid_r, s1_first_r, s1_ki_r, s1_scal_r, s1_fbx0_r;
  q_t     s1_sval_r;
  logic   crd_valid_r, srd_valid_r;
  logic   s2_valid_r, s2_first_r;
  logic signed [63:0] prod_r;
  acc_t   acc_r;

  // Copy pipeline.
  logic           cp_v_r;
  logic [SAW-1:0] cp_addr_r;

  logic [NW-1:0] n;
  logic [TW-1:0] n_t;
  logic          accept;
  logic          sample_go;

  // Memory ports.
  logic [CAW-1:0] c_raddr;
  logic [31:0]    c_rdata;
  logic           c_we;
  logic [SAW-1:0] s_raddr, s_waddr;
  logic [31:0]    s_rdata, s_wdata;
  logic           s_we;

  // Issue decode.
  logic [CAW-1:0] iss_caddr;
  logic [SAW-1:0] iss_saddr;
  logic           iss_ki, iss_scal, iss_last;
  q_t             iss_sval;
  logic [TW-1:0]  tm1, tm2;

  q_t             op_a, op_b, s_eff;
  logic signed [63:0] q_full;
  acc_t           q_term, preload;
  q_t             acc_sat;

  assign n      = (order_r > 3'(MAX_ORDER)) ? NW'(MAX_ORDER) : NW'(order_r);
  assign n_t    = TW'(n);
  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign sample_go = accept && (in_cmd == CMD_SAMPLE);
  assign tm1    = term_r - TW'(1);
  assign tm2    = term_r - TW'(2);

  always_comb begin
    iss_caddr = '0;
    iss_saddr = '0;
    iss_ki    = 1'b0;
    iss_scal  = 1'b0;
    iss_sval  = '0;
    iss_last  = 1'b0;
    case (phase_r)
      PH_FB: begin
        iss_caddr = CAW'(BASE_KFB) + CAW'(term_r);
        iss_saddr = SAW'(BASE_X) + SAW'(term_r);
        iss_last  = (term_r == n_t - TW'(1));
      end
      PH_MODEL: begin
        if (term_r == '0) begin
          iss_caddr = CAW'(BASE_BM) + CAW'(row_r);
          iss_scal  = 1'b1;
          iss_sval  = r_r;
        end else begin
          iss_caddr = CAW'(row_r) * CAW'(MAX_ORDER) + CAW'(tm1);
          iss_saddr = SAW'(BASE_XM) + SAW'(tm1);
        end
        iss_last = (term_r == n_t);
      end
      PH_FF: begin
        iss_caddr = CAW'(BASE_KFF) + CAW'(term_r);
        iss_saddr = SAW'(BASE_XM) + SAW'(term_r);
        iss_last  = (term_r == n_t - TW'(1));
      end
      PH_INT: begin
        iss_ki   = 1'b1;
        iss_scal = 1'b1;
        iss_sval = diff_ry_r;
        iss_last = 1'b1;
      end
      default: begin
        if (term_r == '0) begin
          iss_caddr = CAW'(BASE_L) + CAW'(row_r);
          iss_scal  = 1'b1;
          iss_sval  = diff_yx_r;
        end else if (term_r == TW'(1)) begin
          iss_caddr = CAW'(BASE_B) + CAW'(row_r);
          iss_scal  = 1'b1;
          iss_sval  = u_r;
        end else begin
          iss_caddr = CAW'(row_r) * CAW'(MAX_ORDER) + CAW'(tm2);
          iss_saddr = SAW'(BASE_X) + SAW'(tm2);
        end
        iss_last = (term_r == n_t + TW'(1));
      end
    endcase
  end

  // Coefficient memory: written from write beats, read by the MAC.
  assign c_we    = accept && (in_cmd == CMD_WRITE) && (in_coef_index < 6'(STORE_DEPTH));
  assign c_raddr = iss_caddr;

  ssc_ram #(.WIDTH(32), .DEPTH(STORE_DEPTH)) u_coef_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (in_coef_index[CAW-1:0]),
    .wdata (in_coef_value),
    .raddr (c_raddr),
    .rdata (c_rdata)
  );

  // State memory: finished rows go to scratch, then get copied home so that
  // every row of an update sees the old state vector.
  assign acc_sat = sat32(acc_r);
  assign s_raddr = (state_r == S_COPY) ? SAW'(BASE_SCR) + SAW'(term_r) : iss_saddr;
  always_comb begin
    s_we    = 1'b0;
    s_waddr = SAW'(BASE_SCR) + SAW'(row_r);
    s_wdata = acc_sat;
    if (cp_v_r) begin
      s_we    = 1'b1;
      s_waddr = cp_addr_r;
      s_wdata = s_rdata;
    end else if (state_r == S_DONE && (phase_r == PH_MODEL || phase_r == PH_OBS)) begin
      s_we = 1'b1;
    end
  end

  ssc_ram #(.WIDTH(32), .DEPTH(STATE_DEPTH)) u_state_ram (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (s_raddr),
    .rdata (s_rdata)
  );

  // MAC datapath: operands, product, rounding to nearest with ties upward.
  assign s_eff   = srd_valid_r ? q_t'(s_rdata) : '0;
  assign op_a    = s1_ki_r ? ki_r : (crd_valid_r ? q_t'(c_rdata) : '0);
  assign op_b    = s1_scal_r ? s1_sval_r : s_eff;
  assign q_full  = (prod_r + 64'sd32768) >>> 16;
  assign q_term  = q_full[ACC_W-1:0];
  assign preload = (phase_r == PH_INT) ? acc_t'(integ_r) : '0;

  always_ff @(posedge clk) begin
    crd_valid_r <= cvalid_r[c_raddr];
    srd_valid_r <= svalid_r[s_raddr];
    s1_sval_r   <= iss_sval;
    s1_ki_r     <= iss_ki;
    s1_scal_r   <= iss_scal;
    s1_first_r  <= (term_r == '0);
    s1_fbx0_r   <= (phase_r == PH_FB) && (term_r == '0);
    prod_r      <= op_a * op_b;
    s2_first_r  <= s1_first_r;
    cp_addr_r   <= ((phase_r == PH_MODEL) ? SAW'(BASE_XM) : SAW'(BASE_X)) + SAW'(term_r);
    if (s2_valid_r) begin
      acc_r <= (s2_first_r ? preload : acc_r) + q_term;
    end
    if (s1_valid_r && s1_fbx0_r) begin
      x0_r <= s_eff;
    end
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      cp_v_r     <= 1'b0;
    end else begin
      s1_valid_r <= (state_r == S_ISSUE);
      s2_valid_r <= s1_valid_r;
      cp_v_r     <= (state_r == S_COPY);
    end
  end

  // Sequencer, configuration and result registers.
  always_ff @(posedge clk) begin : ctrl
    acc_t   uw;
    q_t     u0;
    q_t     uc;
    q_t     ic;
    clamp_t sc;
    uw = acc_t'(base_r) + acc_t'(integ_r);
    u0 = sat32(uw);
    uc = u0;
    ic = integ_r;
    sc = CLAMP_NONE;
    if (u0 > umax_r) begin
      uc = umax_r;
      ic = sat32(acc_t'(umax_r) - acc_t'(base_r));
      sc = CLAMP_HIGH;
    end
    if (uc < umin_r) begin
      uc = umin_r;
      ic = sat32(acc_t'(umin_r) - acc_t'(base_r));
      sc = CLAMP_LOW;
    end

    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_FB;
      row_r       <= '0;
      term_r      <= '0;
      wait_r      <= 1'b0;
      order_r     <= 3'd4;
      ki_r        <= '0;
      umax_r      <= 32'sh7fffffff;
      umin_r      <= 32'sh80000000;
      integ_r     <= '0;
      out_valid_r <= 1'b0;
      cvalid_r    <= '0;
      svalid_r    <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_ORDER: order_r <= cfg_wdata[2:0];
          REG_KI:    ki_r    <= cfg_wdata;
          REG_UMAX:  umax_r  <= cfg_wdata;
          REG_UMIN:  umin_r  <= cfg_wdata;
          default:   ;
        endcase
      end
      if (c_we) begin
        cvalid_r[in_coef_index[CAW-1:0]] <= 1'b1;
      end
      if (s_we) begin
        svalid_r[s_waddr] <= 1'b1;
      end
      // A sample leaving S_FINISH refills the output register in the same
      // cycle that the old beat is taken.
      if (out_valid_r && out_ready && state_r != S_FINISH) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (sample_go) begin
            r_r       <= in_reference;
            y_r       <= in_measurement;
            diff_ry_r <= sat32(acc_t'(in_reference) - acc_t'(in_measurement));
            row_r     <= '0;
            term_r    <= '0;
            state_r   <= S_ISSUE;
            if (n == '0) begin
              fb_r    <= '0;
              ff_r    <= '0;
              phase_r <= PH_INT;
            end else begin
              phase_r <= PH_FB;
            end
          end
        end
        S_ISSUE: begin
          if (iss_last) begin
            wait_r  <= 1'b0;
            state_r <= S_WAIT;
          end else begin
            term_r <= term_r + TW'(1);
          end
        end
        S_WAIT: begin
          wait_r <= 1'b1;
          if (wait_r) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          term_r <= '0;
          case (phase_r)
            PH_FB: begin
              fb_r    <= acc_sat;
              phase_r <= PH_MODEL;
              row_r   <= '0;
              state_r <= S_ISSUE;
            end
            PH_FF: begin
              ff_r    <= acc_sat;
              phase_r <= PH_INT;
              state_r <= S_ISSUE;
            end
            PH_INT: begin
              integ_r <= acc_sat;
              state_r <= S_BASE;
            end
            default: begin
              if (row_r == n - NW'(1)) begin
                state_r <= S_COPY;
              end else begin
                row_r   <= row_r + NW'(1);
                state_r <= S_ISSUE;
              end
            end
          endcase
        end
        S_COPY: begin
          if (term_r == n_t - TW'(1)) begin
            state_r <= S_COPY_W;
          end else begin
            term_r <= term_r + TW'(1);
          end
        end
        S_COPY_W: begin
          term_r <= '0;
          row_r  <= '0;
          if (phase_r == PH_MODEL) begin
            phase_r <= PH_FF;
            state_r <= S_ISSUE;
          end else begin
            state_r <= S_FINISH;
          end
        end
        S_BASE: begin
          base_r    <= sat32(acc_t'(ff_r) - acc_t'(fb_r));
          diff_yx_r <= sat32(acc_t'(y_r) - acc_t'(x0_r));
          state_r   <= S_CLAMP;
        end
        S_CLAMP: begin
          u_r      <= uc;
          integ_r  <= ic;
          status_r <= sc;
          row_r    <= '0;
          term_r   <= '0;
          if (n == '0) begin
            state_r <= S_FINISH;
          end else begin
            phase_r <= PH_OBS;
            state_r <= S_ISSUE;
          end
        end
        S_FINISH: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_u_r     <= u_r;
            out_fb_r    <= fb_r;
            out_ff_r    <= ff_r;
            out_st_r    <= status_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid            = out_valid_r;
  assign out_control          = out_u_r;
  assign out_feedback_term    = out_fb_r;
  assign out_feedforward_term = out_ff_r;
  assign out_clamp_status     = out_st_r;

  // The MAC pipe is empty whenever the core is idle.
  a_pipe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (!s1_valid_r && !s2_valid_r && !cp_v_r))
    else $error("MAC pipeline busy while idle");

  // A high clamp only reports when the drive sits at the upper limit.
  a_clamp_high: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_clamp_status == CLAMP_HIGH) |-> (out_control == umax_r))
    else $error("high clamp status without drive at upper limit");

  // A copy write never lands in the scratch rows.
  a_copy_target: assert property (@(posedge clk) disable iff (!rst_n)
    cp_v_r |-> (cp_addr_r < SAW'(BASE_SCR)))
    else $error("state copy aimed at scratch rows");

endmodule

// ----- test/tb_top.sv -----
module tb_top
  import ssc_pkg::*;
();

  // Clock, reset and the block's ports. Every input is driven from time zero.
  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = REG_ORDER;
  logic [31:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_cmd = CMD_WRITE;
  logic [5:0]  in_coef_index = '0;
  q_t          in_coef_value = '0;
  q_t          in_reference = '0;
  q_t          in_measurement = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  q_t          out_control;
  q_t          out_feedback_term;
  q_t          out_feedforward_term;
  logic [1:0]  out_clamp_status;

  always #6 clk = ~clk;

  state_space_servo_controller_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready), .in_cmd(in_cmd),
    .in_coef_index(in_coef_index), .in_coef_value(in_coef_value),
    .in_reference(in_reference), .in_measurement(in_measurement),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_control(out_control), .out_feedback_term(out_feedback_term),
    .out_feedforward_term(out_feedforward_term),
    .out_clamp_status(out_clamp_status)
  );

  // One expected sample result.
  typedef struct packed {
    q_t          control;
    q_t          fb;
    q_t          ff;
    logic [1:0]  status;
  } servo_out_t;

  // The predictor keeps its own copy of everything the block remembers.
  // Values are held as 64-bit signed so that sums can be formed exactly.
  longint     coef_mem [STORE_DEPTH];
  longint     est_x [MAX_ORDER];
  longint     model_x [MAX_ORDER];
  longint     integ;
  logic [2:0] cur_order;
  longint     cur_ki;
  longint     cur_umax;
  longint     cur_umin;

  servo_out_t expected_results[$];
  int         mismatches = 0;
  longint     cycle_count = 0;

  // Idling controls: the sender and receiver idle about 23 percent of the
  // time unless idling is switched off, and the receiver can be held off.
  bit         idle_on = 1'b1;
  bit         hold_sink = 1'b0;
  int         hold_cycles = 0;

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Q16.16 product rounded to nearest with ties toward plus infinity. Adding
  // half an LSB and taking the floor gives exactly that rounding.
  function automatic longint fx_mul(longint a, longint b);
    longint p;
    p = a * b + 64'sd32768;
    return p >>> 16;
  endfunction

  function automatic longint sx32(logic [31:0] v);
    return longint'($signed(v));
  endfunction

  task automatic reset_predictor();
    foreach (coef_mem[i]) coef_mem[i] = 0;
    for (int i = 0; i < MAX_ORDER; i++) begin
      est_x[i] = 0;
      model_x[i] = 0;
    end
    integ = 0;
    cur_order = 3'd4;
    cur_ki = 0;
    cur_umax = 64'sd2147483647;
    cur_umin = -64'sd2147483648;
  endtask

  // Works out the result of one sample beat and advances the predicted state.
  function automatic servo_out_t servo_sample(longint r, longint y);
    servo_out_t res;
    int         n;
    longint     acc, fb, ff, base, u, diff;
    longint     nxt [MAX_ORDER];
    logic [1:0] st;
    n = (cur_order > MAX_ORDER) ? MAX_ORDER : int'(cur_order);
    st = CLAMP_NONE;

    acc = 0;
    for (int i = 0; i < n; i++) acc += fx_mul(coef_mem[BASE_KFB + i], est_x[i]);
    fb = clip32(acc);

    // The reference model advances before its feedforward term is taken.
    for (int i = 0; i < n; i++) begin
      acc = fx_mul(coef_mem[BASE_BM + i], r);
      for (int j = 0; j < n; j++) acc += fx_mul(coef_mem[i * MAX_ORDER + j], model_x[j]);
      nxt[i] = clip32(acc);
    end
    for (int i = 0; i < n; i++) model_x[i] = nxt[i];
    acc = 0;
    for (int i = 0; i < n; i++) acc += fx_mul(coef_mem[BASE_KFF + i], model_x[i]);
    ff = clip32(acc);

    diff = clip32(r - y);
    integ = clip32(integ + fx_mul(cur_ki, diff));
    base = clip32(ff - fb);
    u = clip32(base + integ);
    // High clamp first; the low clamp is checked afterwards and wins when the
    // limits are crossed.
    if (u > cur_umax) begin
      u = cur_umax;
      integ = clip32(cur_umax - base);
      st = CLAMP_HIGH;
    end
    if (u < cur_umin) begin
      u = cur_umin;
      integ = clip32(cur_umin - base);
      st = CLAMP_LOW;
    end

    // The observer uses the clamped drive value.
    if (n > 0) begin
      diff = clip32(y - est_x[0]);
      for (int i = 0; i < n; i++) begin
        acc = fx_mul(coef_mem[BASE_L + i], diff) + fx_mul(coef_mem[BASE_B + i], u);
        for (int j = 0; j < n; j++) acc += fx_mul(coef_mem[i * MAX_ORDER + j], est_x[j]);
        nxt[i] = clip32(acc);
      end
      for (int i = 0; i < n; i++) est_x[i] = nxt[i];
    end

    res.control = q_t'(u);
    res.fb = q_t'(fb);
    res.ff = q_t'(ff);
    res.status = st;
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
    mismatches++;
  endtask

  // Sends one beat and updates the predictor when it is accepted. The valid
  // is held until acceptance; a random gap may follow.
  task automatic send_beat(logic cmd, logic [5:0] idx, logic [31:0] cval,
                           logic [31:0] r, logic [31:0] y);
    in_valid <= 1'b1;
    in_cmd <= cmd;
    in_coef_index <= idx;
    in_coef_value <= cval;
    in_reference <= r;
    in_measurement <= y;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (cmd == CMD_WRITE) begin
      if (idx < STORE_DEPTH) coef_mem[idx] = sx32(cval);
    end else begin
      expected_results.push_back(servo_sample(sx32(r), sx32(y)));
    end
    if (idle_on && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic end_stream();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Waits until every sample has answered, then lets the core settle so that
  // a trailing write or sample cannot overlap a register write.
  task automatic drain();
    end_stream();
    while (expected_results.size() != 0) @(posedge clk);
    repeat (130) @(posedge clk);
  endtask

  // The write enable drops again after each register write, before the task returns.
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_ORDER: cur_order = val[2:0];
      REG_KI:    cur_ki = sx32(val);
      REG_UMAX:  cur_umax = sx32(val);
      default:   cur_umin = sx32(val);
    endcase
  endtask

  task automatic write_coef(int idx, logic [31:0] val);
    send_beat(CMD_WRITE, 6'(idx), val, $urandom, $urandom);
  endtask

  task automatic run_sample(logic [31:0] r, logic [31:0] y);
    send_beat(CMD_SAMPLE, 6'($urandom), $urandom, r, y);
  endtask

  // Coefficients of modest size keep the loops stable, so the state does
  // not simply sit at the rails; occasionally a full-range value is used.
  function automatic logic [31:0] gain_value();
    if ($urandom_range(15) == 0) return $urandom;
    return 32'($signed($urandom_range(0, 98304)) - 49152);
  endfunction

  function automatic logic [31:0] signal_value();
    case ($urandom_range(7))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom;
      default: return 32'($signed($urandom_range(0, 20 << 16)) - (10 << 16));
    endcase
  endfunction

  task automatic load_random_coefs();
    for (int i = 0; i < STORE_DEPTH; i++) write_coef(i, gain_value());
  endtask

  // Result checker: compares each accepted result with the oldest
  // expectation.
  always @(posedge clk) begin
    servo_out_t want;
    cycle_count <= cycle_count + 1;
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result beat", 0, 0);
      end else begin
        want = expected_results.pop_front();
        if (out_control !== want.control)
          report_mismatch("control", out_control, want.control);
        if (out_feedback_term !== want.fb)
          report_mismatch("feedback_term", out_feedback_term, want.fb);
        if (out_feedforward_term !== want.ff)
          report_mismatch("feedforward_term", out_feedforward_term, want.ff);
        if (out_clamp_status !== want.status)
          report_mismatch("clamp_status", out_clamp_status, want.status);
      end
    end
  end

  // Receiver: random stalls, or a counted hold-off when asked.
  always @(posedge clk) begin
    if (hold_sink) begin
      out_ready <= 1'b0;
      if (hold_cycles >= 2000) begin
        hold_sink <= 1'b0;
        hold_cycles <= 0;
      end else begin
        hold_cycles <= hold_cycles + 1;
      end
    end else begin
      out_ready <= idle_on ? ($urandom_range(99) >= 23) : 1'b1;
    end
  end

  // Watchdog: fails the run once the cycle count passes a wide margin over
  // the slowest run with its stalls.
  always @(posedge clk) begin
    if (cycle_count > 1500000) begin
      $display("** state_space_servo_controller_core: FAILED **");
      $finish;
    end
  end

  // Directed: rails of every field, both commands, ignored addresses.
  task automatic test_directed();
    write_coef(0, 32'h00010000);
    write_coef(BASE_BM, 32'h00010000);
    write_coef(BASE_KFF, 32'h7fffffff);
    write_coef(BASE_KFB, 32'h80000000);
    write_coef(BASE_B, 32'h00008000);
    write_coef(BASE_L, 32'hffff8000);
    write_coef(63, 32'hffffffff);
    write_coef(STORE_DEPTH, 32'h12345678);
    run_sample(32'h7fffffff, 32'h80000000);
    run_sample(32'h80000000, 32'h7fffffff);
    run_sample(32'h00000000, 32'h00000000);
    run_sample(32'hffffffff, 32'h00000001);
    run_sample(32'h00018000, 32'hffff8000);
    write_coef(BASE_KFF + 3, 32'h7fffffff);
    write_coef(15, 32'h80000000);
    run_sample(32'h7fffffff, 32'h7fffffff);
    run_sample(32'h55555555, 32'haaaaaaaa);
    drain();
  endtask

  // Order sweep: zero, every legal order and the values above the maximum.
  task automatic test_orders();
    load_random_coefs();
    for (int k = 0; k < 8; k++) begin
      drain();
      write_reg(REG_ORDER, 32'(k));
      for (int s = 0; s < 6; s++) run_sample(signal_value(), signal_value());
    end
    drain();
  endtask

  // Clamp limits: crossed limits, rails and narrow windows, some with a large
  // integral gain so that the integrator runs into them.
  task automatic test_clamps();
    logic [31:0] hi, lo;
    for (int k = 0; k < 8; k++) begin
      drain();
      case (k)
        0: begin hi = 32'h7fffffff; lo = 32'h80000000; end
        1: begin hi = 32'h80000000; lo = 32'h7fffffff; end
        2: begin hi = 32'h00010000; lo = 32'hffff0000; end
        3: begin hi = 32'h00000000; lo = 32'h00000000; end
        4: begin hi = 32'hfff00000; lo = 32'h00100000; end
        default: begin hi = $urandom; lo = $urandom; end
      endcase
      write_reg(REG_UMAX, hi);
      write_reg(REG_UMIN, lo);
      write_reg(REG_KI, (k == 3) ? 32'h80000000 : (k == 4 ? 32'h7fffffff : gain_value()));
      write_reg(REG_ORDER, 32'($urandom_range(0, 7)));
      for (int s = 0; s < 10; s++) run_sample(signal_value(), signal_value());
    end
    drain();
  endtask

  // Receiver held off long while samples keep coming, then the sender waits
  // for every result before going on.
  task automatic test_backpressure();
    write_reg(REG_ORDER, 32'd4);
    write_reg(REG_UMAX, 32'h00400000);
    write_reg(REG_UMIN, 32'hffc00000);
    hold_sink = 1'b1;
    for (int s = 0; s < 20; s++) run_sample(signal_value(), signal_value());
    drain();
  endtask

  // Random part: mostly samples under sane limits, coefficient rewrites mixed
  // in, and phases with new settings in between. One phase runs without idles.
  task automatic test_random();
    int sent;
    sent = 0;
    for (int ph = 0; sent < 1300; ph++) begin
      drain();
      idle_on = (ph != 3);
      write_reg(REG_ORDER, 32'($urandom_range(0, 7)));
      write_reg(REG_KI, gain_value());
      if ($urandom_range(3) == 0) begin
        write_reg(REG_UMAX, $urandom);
        write_reg(REG_UMIN, $urandom);
      end else begin
        write_reg(REG_UMAX, 32'($urandom_range(1 << 16, 200 << 16)));
        write_reg(REG_UMIN, 32'(-$signed(32'($urandom_range(1 << 16, 200 << 16)))));
      end
      if ($urandom_range(2) == 0) load_random_coefs();
      for (int s = 0; s < 80; s++) begin
        if ($urandom_range(9) == 0)
          write_coef($urandom_range(0, 63), gain_value());
        else
          run_sample(signal_value(), signal_value());
        sent++;
      end
    end
    idle_on = 1'b1;
    drain();
  endtask

  initial begin
    reset_predictor();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_orders();
    test_clamps();
    test_backpressure();
    test_random();
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("** state_space_servo_controller_core: PASSED **");
    end else begin
      if (expected_results.size() != 0)
        $display("%0d results never arrived", expected_results.size());
      $display("** state_space_servo_controller_core: FAILED **");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/ssc_pkg.sv
rtl/ssc_ram.sv
rtl/state_space_servo_controller_core.sv
test/tb_top.sv
